// ----- rtl/core/inactivity_batch_closer_core_assert.svh -----
// Assertion helpers for the core modules, included by ibc_back
`ifndef INACTIVITY_BATCH_CLOSER_CORE_ASSERT_SVH
`define INACTIVITY_BATCH_CLOSER_CORE_ASSERT_SVH

// same-cycle implication
`define IBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ibc_pkg.sv -----
// ----------------------------------------------------------------------------
// ibc_pkg
// Types and constants of the inactivity batch closer.
// ----------------------------------------------------------------------------
package ibc_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int SLOTS_MAX     = 64;
    localparam int ADDR_MAX_W    = 6;

    typedef enum logic [2:0] {
        FN_ADVANCE = 3'd0,
        FN_COMMIT  = 3'd1,
        FN_TICK    = 3'd2,
        FN_RECOVER = 3'd3,
        FN_NEW_DAY = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_UNHEALTHY    = 3'd1,
        ST_DOUBLE_ADV   = 3'd2,
        ST_TIME_BACK    = 3'd3,
        ST_NO_ADVANCE   = 3'd4,
        ST_SEQ_GAP      = 3'd5,
        ST_BAD_CAND     = 3'd6,
        ST_TIMER_OPEN   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CR_NONE  = 2'd0,
        CR_EVENT = 2'd1,
        CR_TIMER = 2'd2
    } reason_t;

    typedef enum logic {
        F_IDLE,
        F_EXEC
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_WALK
    } back_state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] time_ns;
        logic        sequence_ok;
        logic        has_candidate;
        logic        instrument_present;
        logic [4:0]  instrument_slot;
        logic [63:0] cut_number;
        logic [63:0] feed_sequence;
        logic [63:0] exchange_time_us;
        logic [63:0] candidate_receive_ns;
    } ibc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  close_reason;
        logic [63:0] batch_number;
        logic [63:0] last_activity_out;
        logic [63:0] inactivity_out;
        logic        candidate_valid;
        logic [4:0]  out_slot;
        logic [63:0] out_cut;
        logic [63:0] out_sequence;
        logic [63:0] out_exchange_time_us;
        logic [63:0] out_receive_ns;
        logic        last_of_run;
    } ibc_out_t;

    // work handed from front to back
    typedef struct packed {
        logic                 is_close;
        status_t              status;
        reason_t              reason;
        logic [63:0]          batch;
        logic [63:0]          last_act;
        logic [63:0]          inact;
        logic [SLOTS_MAX-1:0] mask;
    } ibc_job_t;

    typedef struct packed {
        logic                  walk;
        logic [ADDR_MAX_W-1:0] addr;
    } ibc_rdreq_t;

    typedef struct packed {
        logic [63:0] cut;
        logic [63:0] seq;
        logic [63:0] xtime;
        logic [63:0] rtime;
    } ibc_pdata_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_MAX_W-1:0] addr;
        logic [63:0]           cut;
    } ibc_ewr_t;

endpackage

// ----- rtl/core/ibc_queue.sv -----
// ----------------------------------------------------------------------------
// ibc_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module ibc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ibc_pkg::ibc_job_t push_job,
    input  logic            pop,
    output logic            q_valid,
    output ibc_pkg::ibc_job_t q_job
);
    import ibc_pkg::*;

    ibc_job_t   mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign q_valid = (cnt_reg != 2'd0);
    assign q_job   = mem_reg[rptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = ~wptr_reg;
        end
        if (do_pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/ibc_front.sv -----
// ----------------------------------------------------------------------------
// ibc_front
// Accepts items, classifies them, keeps batch state and candidate stores.
// ----------------------------------------------------------------------------
module ibc_front #(
    parameter int INSTRUMENT_SLOTS = ibc_pkg::SLOTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  ibc_pkg::ibc_in_t     cmd,
    input  logic                 threshold_we,
    input  logic [63:0]          threshold,
    input  ibc_pkg::ibc_rdreq_t  rdreq,
    input  ibc_pkg::ibc_ewr_t    ewr,
    output ibc_pkg::ibc_pdata_t  pdata,
    output logic                 front_busy,
    output logic                 push,
    output ibc_pkg::ibc_job_t    push_job
);
    import ibc_pkg::*;

    localparam int N  = INSTRUMENT_SLOTS;
    localparam int AW = (N > 1) ? $clog2(N) : 1;

    front_state_t state_reg, state_next;
    ibc_in_t      item_reg;

    logic         healthy_reg, healthy_next;
    logic         open_reg, open_next;
    logic         active_reg, active_next;
    logic [63:0]  open_time_reg, open_time_next;
    logic [63:0]  last_reg, last_next;
    logic [63:0]  cur_reg, cur_next;
    logic [63:0]  nxt_reg, nxt_next;
    logic [63:0]  thr_reg;
    logic [N-1:0] pv_reg, pv_next;
    logic [N-1:0] ev_reg, ev_next;

    logic [63:0]  pcut_mem [N];
    logic [63:0]  pseq_mem [N];
    logic [63:0]  pxt_mem  [N];
    logic [63:0]  prt_mem  [N];
    logic [63:0]  ecut_mem [N];
    logic [63:0]  ecut_rd_reg;

    logic [6:0]    in_slot7, item_slot7;
    logic [AW-1:0] rd_addr, item_addr;
    logic          pwr;
    logic          ge, gap, in_range, bad, stale;
    logic [63:0]   diff, inact;

    assign in_slot7   = {2'b00, cmd.instrument_slot};
    assign item_slot7 = {2'b00, item_reg.instrument_slot};
    assign item_addr  = item_slot7[AW-1:0];
    assign rd_addr    = rdreq.walk ? rdreq.addr[AW-1:0] : in_slot7[AW-1:0];
    assign front_busy = (state_reg == F_EXEC);

    assign diff     = item_reg.time_ns - last_reg;
    assign ge       = (item_reg.time_ns >= last_reg);
    assign gap      = ge && (diff > thr_reg);
    assign inact    = ge ? diff : 64'd0;
    assign in_range = (item_slot7 < 7'(N));
    assign bad      = !item_reg.instrument_present || (item_reg.cut_number == 64'd0)
                      || (item_reg.candidate_receive_ns != open_time_reg) || !in_range;
    assign stale    = (ev_reg[item_addr] && (item_reg.cut_number <= ecut_rd_reg))
                      || (pv_reg[item_addr] && (item_reg.cut_number <= pdata.cut));

    always_comb
    begin
        unique case (state_reg)
            F_IDLE:  state_next = accept ? F_EXEC : F_IDLE;
            F_EXEC:  state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        healthy_next   = healthy_reg;
        open_next      = open_reg;
        active_next    = active_reg;
        open_time_next = open_time_reg;
        last_next      = last_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        pv_next        = pv_reg;
        ev_next        = ev_reg;
        pwr            = 1'b0;
        push           = 1'b0;
        push_job       = '0;
        push_job.status = ST_OK;
        push_job.reason = CR_NONE;

        if (ewr.en)
        begin
            ev_next[ewr.addr[AW-1:0]] = 1'b1;
        end

        if (state_reg == F_EXEC)
        begin
            push = 1'b1;
            unique case (func_t'(item_reg.func))
                FN_ADVANCE:
                begin
                    if (!healthy_reg)
                    begin
                        push_job.status = ST_UNHEALTHY;
                    end
                    else if (open_reg)
                    begin
                        push_job.status = ST_DOUBLE_ADV;
                    end
                    else if (active_reg && !ge)
                    begin
                        push_job.status = ST_TIME_BACK;
                        healthy_next    = 1'b0;
                        active_next     = 1'b0;
                        open_next       = 1'b0;
                        open_time_next  = 64'd0;
                        last_next       = 64'd0;
                        cur_next        = 64'd0;
                        pv_next         = '0;
                    end
                    else
                    begin
                        if (active_reg && gap)
                        begin
                            push_job.is_close       = 1'b1;
                            push_job.reason         = CR_EVENT;
                            push_job.batch          = cur_reg;
                            push_job.last_act       = last_reg;
                            push_job.inact          = inact;
                            push_job.mask[N-1:0]    = pv_reg;
                            active_next             = 1'b0;
                            last_next               = 64'd0;
                            cur_next                = 64'd0;
                            pv_next                 = '0;
                        end
                        open_time_next = item_reg.time_ns;
                        open_next      = 1'b1;
                    end
                end
                FN_COMMIT:
                begin
                    if (!healthy_reg)
                    begin
                        push_job.status = ST_UNHEALTHY;
                    end
                    else if (!open_reg)
                    begin
                        push_job.status = ST_NO_ADVANCE;
                    end
                    else if (!item_reg.sequence_ok || (item_reg.has_candidate && bad))
                    begin
                        push_job.status = item_reg.sequence_ok ? ST_BAD_CAND : ST_SEQ_GAP;
                        // a new batch number is still consumed on a bad candidate when no batch is active
                        if (item_reg.sequence_ok && !active_reg)
                        begin
                            nxt_next = nxt_reg + 64'd1;
                        end
                        healthy_next   = 1'b0;
                        active_next    = 1'b0;
                        open_next      = 1'b0;
                        open_time_next = 64'd0;
                        last_next      = 64'd0;
                        cur_next       = 64'd0;
                        pv_next        = '0;
                    end
                    else
                    begin
                        if (!active_reg)
                        begin
                            active_next = 1'b1;
                            cur_next    = nxt_reg;
                            nxt_next    = nxt_reg + 64'd1;
                        end
                        last_next = open_time_reg;
                        if (item_reg.has_candidate && !stale)
                        begin
                            pwr                = 1'b1;
                            pv_next[item_addr] = 1'b1;
                        end
                        open_next      = 1'b0;
                        open_time_next = 64'd0;
                    end
                end
                FN_TICK:
                begin
                    if (!healthy_reg)
                    begin
                        push_job.status = ST_UNHEALTHY;
                    end
                    else if (open_reg)
                    begin
                        push_job.status = ST_TIMER_OPEN;
                    end
                    else if (active_reg && gap)
                    begin
                        push_job.is_close    = 1'b1;
                        push_job.reason      = CR_TIMER;
                        push_job.batch       = cur_reg;
                        push_job.last_act    = last_reg;
                        push_job.inact       = inact;
                        push_job.mask[N-1:0] = pv_reg;
                        active_next          = 1'b0;
                        open_time_next       = 64'd0;
                        last_next            = 64'd0;
                        cur_next             = 64'd0;
                        pv_next              = '0;
                    end
                end
                FN_RECOVER, FN_NEW_DAY:
                begin
                    healthy_next   = 1'b1;
                    active_next    = 1'b0;
                    open_next      = 1'b0;
                    open_time_next = 64'd0;
                    last_next      = 64'd0;
                    cur_next       = 64'd0;
                    pv_next        = '0;
                    if (func_t'(item_reg.func) == FN_NEW_DAY)
                    begin
                        ev_next  = '0;
                        nxt_next = 64'd1;
                    end
                end
                default:
                begin
                    push_job.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        pdata.cut   <= pcut_mem[rd_addr];
        pdata.seq   <= pseq_mem[rd_addr];
        pdata.xtime <= pxt_mem[rd_addr];
        pdata.rtime <= prt_mem[rd_addr];
        ecut_rd_reg <= ecut_mem[rd_addr];
        if (pwr)
        begin
            pcut_mem[item_addr] <= item_reg.cut_number;
            pseq_mem[item_addr] <= item_reg.feed_sequence;
            pxt_mem[item_addr]  <= item_reg.exchange_time_us;
            prt_mem[item_addr]  <= item_reg.candidate_receive_ns;
        end
        if (ewr.en)
        begin
            ecut_mem[ewr.addr[AW-1:0]] <= ewr.cut;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            healthy_reg   <= 1'b1;
            open_reg      <= 1'b0;
            active_reg    <= 1'b0;
            open_time_reg <= 64'd0;
            last_reg      <= 64'd0;
            cur_reg       <= 64'd0;
            nxt_reg       <= 64'd1;
            thr_reg       <= 64'd0;
            pv_reg        <= '0;
            ev_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            healthy_reg   <= healthy_next;
            open_reg      <= open_next;
            active_reg    <= active_next;
            open_time_reg <= open_time_next;
            last_reg      <= last_next;
            cur_reg       <= cur_next;
            nxt_reg       <= nxt_next;
            pv_reg        <= pv_next;
            ev_reg        <= ev_next;
            if (threshold_we)
            begin
                thr_reg <= threshold;
            end
        end
    end

endmodule

// ----- rtl/core/ibc_back.sv -----
// ----------------------------------------------------------------------------
// ibc_back
// Turns jobs into result beats; walks the pending slots of a closed batch.
// ----------------------------------------------------------------------------
`include "inactivity_batch_closer_core_assert.svh"

module ibc_back #(
    parameter int INSTRUMENT_SLOTS = ibc_pkg::SLOTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  ibc_pkg::ibc_job_t    q_job,
    input  ibc_pkg::ibc_pdata_t  pdata,
    output logic                 pop,
    output ibc_pkg::ibc_rdreq_t  rdreq,
    output ibc_pkg::ibc_ewr_t    ewr,
    output logic                 back_busy,
    output logic                 done,
    output ibc_pkg::ibc_out_t    result
);
    import ibc_pkg::*;

    localparam int N  = INSTRUMENT_SLOTS;
    localparam int AW = (N > 1) ? $clog2(N) : 1;

    back_state_t   state_reg, state_next;
    ibc_job_t      job_reg, job_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pslot_reg, pslot_next;
    ibc_out_t      out_reg, out_next;
    logic          done_reg, done_next;

    logic [N-1:0]  mask;
    logic [N-1:0]  rest;
    logic          emit, last;

    assign mask      = job_reg.mask[N-1:0];
    assign rest      = (mask >> pslot_reg) >> 1;
    assign emit      = (state_reg == B_WALK) && pend_reg && mask[pslot_reg];
    assign last      = (rest == '0);
    assign back_busy = (state_reg == B_WALK);
    assign done      = done_reg;
    assign result    = out_reg;

    always_comb
    begin
        unique case (state_reg)
            B_IDLE:  state_next = (q_valid && q_job.is_close &&
                                   (q_job.mask[N-1:0] != '0)) ? B_WALK : B_IDLE;
            B_WALK:  state_next = (emit && last) ? B_IDLE : B_WALK;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        pslot_next = pslot_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        rdreq      = '0;
        ewr        = '0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    job_next   = q_job;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    pslot_next = '0;
                    if (!q_job.is_close || (q_job.mask[N-1:0] == '0))
                    begin
                        // single result or header-only close
                        out_next                   = '0;
                        out_next.status            = q_job.status;
                        out_next.close_reason      = q_job.reason;
                        out_next.batch_number      = q_job.batch;
                        out_next.last_activity_out = q_job.last_act;
                        out_next.inactivity_out    = q_job.inact;
                        out_next.last_of_run       = 1'b1;
                        done_next                  = 1'b1;
                    end
                end
            end
            B_WALK:
            begin
                rdreq.walk = 1'b1;
                rdreq.addr = ADDR_MAX_W'(cnt_reg[AW-1:0]);
                pend_next  = (cnt_reg < (AW+1)'(N));
                pslot_next = cnt_reg[AW-1:0];
                cnt_next   = cnt_reg + (AW+1)'(1);
                if (emit)
                begin
                    out_next.status               = job_reg.status;
                    out_next.close_reason         = job_reg.reason;
                    out_next.batch_number         = job_reg.batch;
                    out_next.last_activity_out    = job_reg.last_act;
                    out_next.inactivity_out       = job_reg.inact;
                    out_next.candidate_valid      = 1'b1;
                    out_next.out_slot             = 5'(pslot_reg);
                    out_next.out_cut              = pdata.cut;
                    out_next.out_sequence         = pdata.seq;
                    out_next.out_exchange_time_us = pdata.xtime;
                    out_next.out_receive_ns       = pdata.rtime;
                    out_next.last_of_run          = last;
                    done_next                     = 1'b1;
                    ewr.en                        = 1'b1;
                    ewr.addr                      = ADDR_MAX_W'(pslot_reg);
                    ewr.cut                       = pdata.cut;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        pslot_reg <= pslot_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    `IBC_ASSERT_NOW(a_hdr_is_last, done_reg && !out_reg.candidate_valid,
        out_reg.last_of_run, "result without candidate must end its run")
    `IBC_ASSERT_NOW(a_close_ok, done_reg && (out_reg.close_reason != CR_NONE),
        out_reg.status == ST_OK, "closing result with error status")
    `IBC_ASSERT_NEXT(a_no_spurious, (state_reg == B_IDLE) && !q_valid,
        !done_reg, "result beat without a job")

endmodule

// ----- rtl/core/inactivity_batch_closer_core.sv -----
// ----------------------------------------------------------------------------
// inactivity_batch_closer_core
// Groups market-data events into batches closed by an inactivity gap.
// ----------------------------------------------------------------------------
// Usage:
//   An item on cmd is taken when start is high and busy is low. Results come
//   out on result, one beat per cycle while done is high; the receiver cannot
//   stall, so every beat must be taken in the cycle it is shown.
//   threshold_we/threshold load the gap threshold; the user must write it
//   only while the block is idle, as the block itself does not enforce this.
// Flow:
//   Single-result item: the front registers it (store lookup at the accepting
//   edge), the queue holds the job, the back part registers result and done.
//   Closing item: one beat per pending slot, in ascending slot order; a
//   header-only close is a single result. busy covers front, queue and walk.
// Reset:
//   rst_n clears all control state and valid bits at once; candidate data is
//   only read behind its valid bit. The block is ready right after reset.
// ----------------------------------------------------------------------------
module inactivity_batch_closer_core #(
    parameter int INSTRUMENT_SLOTS = ibc_pkg::SLOTS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ibc_pkg::ibc_in_t  cmd,
    input  logic              threshold_we,
    input  logic [63:0]       threshold,
    output logic              done,
    output ibc_pkg::ibc_out_t result
);
    import ibc_pkg::*;

    logic       front_busy, back_busy, accept;
    logic       push, pop, q_valid;
    ibc_job_t   push_job, q_job;
    ibc_rdreq_t rdreq;
    ibc_ewr_t   ewr;
    ibc_pdata_t pdata;

    assign busy   = front_busy || q_valid || back_busy;
    assign accept = start && !busy;

    ibc_front #(
        .INSTRUMENT_SLOTS(INSTRUMENT_SLOTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cmd          (cmd),
        .threshold_we (threshold_we),
        .threshold    (threshold),
        .rdreq        (rdreq),
        .ewr          (ewr),
        .pdata        (pdata),
        .front_busy   (front_busy),
        .push         (push),
        .push_job     (push_job)
    );

    ibc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    ibc_back #(
        .INSTRUMENT_SLOTS(INSTRUMENT_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pdata     (pdata),
        .pop       (pop),
        .rdreq     (rdreq),
        .ewr       (ewr),
        .back_busy (back_busy),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- dv/tb_inactivity_batch_closer_core.sv -----
// ----------------------------------------------------------------------------
// tb_inactivity_batch_closer_core
// Drives advance/commit/tick/recover/new-day commands through the batch closer
// and checks every result beat against an in-bench batch predictor.
// ----------------------------------------------------------------------------
module tb_inactivity_batch_closer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ibc_pkg::*;

    localparam int SLOTS = 32;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 20;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ibc_in_t  cmd;
    logic     threshold_we;
    logic [63:0] threshold;
    logic     done;
    ibc_out_t result;

    inactivity_batch_closer_core #(.INSTRUMENT_SLOTS(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .threshold_we(threshold_we), .threshold(threshold),
        .done(done), .result(result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // predictor state
    logic [63:0] gap_thr;
    logic        healthy, ev_open, b_active;
    logic [63:0] open_time, last_act, cur_batch, next_batch;
    logic        pend_v [SLOTS];
    logic [63:0] pend_cut [SLOTS];
    logic [63:0] pend_seq [SLOTS];
    logic [63:0] pend_xt [SLOTS];
    logic [63:0] pend_rt [SLOTS];
    logic        emit_v [SLOTS];
    logic [63:0] emit_cut [SLOTS];

    ibc_in_t  cmd_q [$];
    ibc_out_t beats_due [$];
    int       errors = 0;
    int       mismatches = 0;
    int       sender_idle_pct;

    // set while the item on the bus has not yet been taken
    int       in_flight;

    // busy as seen at the last rising edge
    logic     busy_at_edge;

    function automatic void add_beat(ibc_out_t r);
        beats_due.insert(beats_due.size(), r);
    endfunction

    function automatic void add_cmd(ibc_in_t c);
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    function automatic ibc_out_t lone_beat(status_t st);
        ibc_out_t r;
        r = '0;
        r.status = st;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    function automatic void drop_batch();
        b_active = 1'b0;
        ev_open = 1'b0;
        open_time = '0;
        last_act = '0;
        cur_batch = '0;
        for (int s = 0; s < SLOTS; s++)
            pend_v[s] = 1'b0;
    endfunction

    function automatic void model_reset();
        gap_thr = '0;
        healthy = 1'b1;
        next_batch = 64'd1;
        drop_batch();
        for (int s = 0; s < SLOTS; s++)
        begin
            emit_v[s] = 1'b0;
            pend_cut[s] = '0;
            pend_seq[s] = '0;
            pend_xt[s] = '0;
            pend_rt[s] = '0;
            emit_cut[s] = '0;
        end
    endfunction

    function automatic logic gap_over(logic [63:0] now);
        return now >= last_act && (now - last_act) > gap_thr;
    endfunction

    function automatic void close_out(logic [63:0] now, reason_t why);
        ibc_out_t r;
        int       n;
        n = 0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (pend_v[s])
            begin
                r = '0;
                r.close_reason = why;
                r.batch_number = cur_batch;
                r.last_activity_out = last_act;
                r.inactivity_out = now >= last_act ? now - last_act : '0;
                r.candidate_valid = 1'b1;
                r.out_slot = s[4:0];
                r.out_cut = pend_cut[s];
                r.out_sequence = pend_seq[s];
                r.out_exchange_time_us = pend_xt[s];
                r.out_receive_ns = pend_rt[s];
                emit_v[s] = 1'b1;
                emit_cut[s] = pend_cut[s];
                add_beat(r);
                n++;
            end
        end
        if (n == 0)
        begin
            r = '0;
            r.close_reason = why;
            r.batch_number = cur_batch;
            r.last_activity_out = last_act;
            r.inactivity_out = now >= last_act ? now - last_act : '0;
            add_beat(r);
        end
        beats_due[$].last_of_run = 1'b1;
        drop_batch();
    endfunction

    function automatic void predict_batch(ibc_in_t c);
        logic [4:0] sl;
        sl = c.instrument_slot;
        case (c.func)
            FN_ADVANCE:
                if (!healthy) add_beat(lone_beat(ST_UNHEALTHY));
                else if (ev_open) add_beat(lone_beat(ST_DOUBLE_ADV));
                else if (b_active && c.time_ns < last_act)
                begin
                    drop_batch();
                    healthy = 1'b0;
                    add_beat(lone_beat(ST_TIME_BACK));
                end
                else
                begin
                    if (b_active && gap_over(c.time_ns))
                        close_out(c.time_ns, CR_EVENT);
                    else
                        add_beat(lone_beat(ST_OK));
                    open_time = c.time_ns;
                    ev_open = 1'b1;
                end
            FN_COMMIT:
                if (!healthy) add_beat(lone_beat(ST_UNHEALTHY));
                else if (!ev_open) add_beat(lone_beat(ST_NO_ADVANCE));
                else if (!c.sequence_ok)
                begin
                    drop_batch();
                    healthy = 1'b0;
                    add_beat(lone_beat(ST_SEQ_GAP));
                end
                else
                begin
                    if (!b_active)
                    begin
                        b_active = 1'b1;
                        cur_batch = next_batch;
                        next_batch = next_batch + 64'd1;
                    end
                    last_act = open_time;
                    if (c.has_candidate && (!c.instrument_present || c.cut_number == 0
                        || c.candidate_receive_ns != open_time))
                    begin
                        drop_batch();
                        healthy = 1'b0;
                        add_beat(lone_beat(ST_BAD_CAND));
                    end
                    else
                    begin
                        if (c.has_candidate
                            && !((emit_v[sl] && c.cut_number <= emit_cut[sl])
                                 || (pend_v[sl] && c.cut_number <= pend_cut[sl])))
                        begin
                            pend_v[sl] = 1'b1;
                            pend_cut[sl] = c.cut_number;
                            pend_seq[sl] = c.feed_sequence;
                            pend_xt[sl] = c.exchange_time_us;
                            pend_rt[sl] = c.candidate_receive_ns;
                        end
                        ev_open = 1'b0;
                        open_time = '0;
                        add_beat(lone_beat(ST_OK));
                    end
                end
            FN_TICK:
                if (!healthy) add_beat(lone_beat(ST_UNHEALTHY));
                else if (ev_open) add_beat(lone_beat(ST_TIMER_OPEN));
                else if (!b_active || !gap_over(c.time_ns))
                    add_beat(lone_beat(ST_OK));
                else
                    close_out(c.time_ns, CR_TIMER);
            FN_RECOVER:
            begin
                drop_batch();
                healthy = 1'b1;
                add_beat(lone_beat(ST_OK));
            end
            FN_NEW_DAY:
            begin
                drop_batch();
                for (int s = 0; s < SLOTS; s++)
                    emit_v[s] = 1'b0;
                healthy = 1'b1;
                next_batch = 64'd1;
                add_beat(lone_beat(ST_OK));
            end
            default:
                add_beat(lone_beat(ST_OK));
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic ibc_in_t noise_cmd();
        logic [383:0] raw;
        ibc_in_t      c;
        raw = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64()};
        c = raw[$bits(ibc_in_t)-1:0];
        return c;
    endfunction

    // one advance/commit pair, mostly with a candidate, with a broken commit when bad is set
    task automatic queue_event(input logic [63:0] t, input int slot_hi, input logic bad);
        ibc_in_t a;
        ibc_in_t c;
        a = '0;
        a.func = FN_ADVANCE;
        a.time_ns = t;
        c = noise_cmd();
        c.func = FN_COMMIT;
        c.time_ns = rand64();
        c.sequence_ok = 1'b1;
        c.has_candidate = ($urandom_range(0, 4) != 0);
        c.instrument_present = 1'b1;
        c.instrument_slot = 5'($urandom_range(0, slot_hi));
        c.cut_number = 64'($urandom_range(1, 12));
        if ($urandom_range(0, 9) == 0)
            c.cut_number = rand64() | 64'd1;
        c.candidate_receive_ns = t;
        if (bad)
        begin
            case ($urandom_range(0, 3))
                0: c.sequence_ok = 1'b0;
                1: c.instrument_present = 1'b0;
                2: c.cut_number = '0;
                default: c.candidate_receive_ns = t + 64'd1;
            endcase
        end
        add_cmd(a);
        add_cmd(c);
    endtask

    task automatic queue_simple(input func_t f, input logic [63:0] t);
        ibc_in_t c;
        c = noise_cmd();
        c.func = f;
        c.time_ns = t;
        add_cmd(c);
    endtask

    task automatic wait_quiet();
        while (cmd_q.size() != 0 || in_flight != 0 || beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [63:0] v);
        @(negedge clk);
        threshold_we <= 1'b1;
        threshold <= v;
        @(negedge clk);
        threshold_we <= 1'b0;
    endtask

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            in_flight = 0;
        end
        else
        begin
            if (start && !busy_at_edge)
            begin
                start <= 1'b0;
                in_flight = 0;
            end
            if ((!start || !busy_at_edge) && cmd_q.size() != 0
                && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                cmd <= cmd_q[0];
                start <= 1'b1;
                in_flight = 1;
                void'(cmd_q.pop_front());
            end
        end
    end

    // accept tracking and result checking at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_at_edge <= 1'b1;
            model_reset();
        end
        else
        begin
            busy_at_edge <= busy;
            if (threshold_we)
                gap_thr = threshold;
            if (start && !busy)
                predict_batch(cmd);
            if (done)
            begin
                if (beats_due.size() == 0)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected beat: %p", result);
                    mismatches++;
                end
                else
                begin
                    if (result !== beats_due[0])
                    begin
                        errors++;
                        if (mismatches < 10)
                            $display("beat mismatch:\n  exp %p\n  got %p", beats_due[0],
                                     result);
                        mismatches++;
                    end
                    void'(beats_due.pop_front());
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [63:0] t;
        logic [63:0] thr_set [4];
        int          pct_set [4];
        sender_idle_pct = 0;
        threshold_we = 1'b0;
        threshold = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: threshold 0, every func and error, with one random kind of broken commit
        set_threshold(64'd0);
        queue_simple(FN_COMMIT, 64'd5);                  // commit without advance
        queue_simple(FN_TICK, 64'd5);                    // tick with nothing open
        queue_event(64'd100, 31, 1'b0);
        queue_simple(FN_ADVANCE, 64'd100);               // equal time, no close
        queue_simple(FN_ADVANCE, 64'd101);               // double advance
        queue_simple(FN_TICK, 64'd200);                  // timer during open event
        add_cmd(ibc_in_t'{func: FN_COMMIT, time_ns: 64'd0, sequence_ok: 1'b1,
                          has_candidate: 1'b1, instrument_present: 1'b1,
                          instrument_slot: 5'd0, cut_number: '1,
                          feed_sequence: '1, exchange_time_us: '1,
                          candidate_receive_ns: 64'd100});
        queue_simple(FN_TICK, 64'd101);                  // timer close
        queue_event(64'd300, 0, 1'b0);
        queue_simple(FN_ADVANCE, 64'd5);                 // time backwards
        queue_simple(FN_TICK, 64'd1000);                 // unhealthy
        queue_simple(FN_RECOVER, 64'd0);
        queue_event(64'd400, 3, 1'b1);                   // broken commit
        queue_simple(FN_NEW_DAY, 64'd0);
        queue_simple(func_t'(3'd7), '1);                 // unknown func
        queue_event(64'd500, 31, 1'b0);
        queue_simple(FN_ADVANCE, '1);                    // close by next event
        wait_quiet();

        thr_set = '{64'd0, 64'd40, 64'd1000, '1};
        pct_set = '{0, 86, 0, 32};
        t = 64'd1000;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_threshold(thr_set[ph]);
            sender_idle_pct = pct_set[ph];
            queue_simple(FN_NEW_DAY, 64'd0);
            for (int k = 0; k < 25; k++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_simple(func_t'(3'($urandom_range(0, 7))), rand64());
                    1: queue_simple(FN_TICK, t + 64'($urandom_range(0, 2000)));
                    2: queue_event(t, 31, 1'b1);
                    3: queue_simple(FN_RECOVER, t);
                    default: queue_event(t, 3, 1'b0);
                endcase
                t = t + 64'($urandom_range(0, 1500));
            end
            if (ph == 1)
            begin
                // hold off until everything queued has come out
                wait_quiet();
            end
            queue_simple(FN_TICK, t + 64'd5000);
            wait_quiet();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- inactivity_batch_closer_core.f -----
+incdir+rtl/core
rtl/core/ibc_pkg.sv
rtl/core/ibc_queue.sv
rtl/core/ibc_front.sv
rtl/core/ibc_back.sv
rtl/core/inactivity_batch_closer_core.sv
dv/tb_inactivity_batch_closer_core.sv
